/* rtl/core/mppt_po_pkg.sv */
// ----------------------------------------------------------------------------
// mppt_po_pkg
// Shared codes, constants and controller/datapath interface types for the
// perturb-and-observe tracker with redline protection.
// ----------------------------------------------------------------------------
package mppt_po_pkg;

    localparam int unsigned DATA_W = 16;
    localparam int unsigned STEP_W = 12;
    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned IN_TDATA_W = 72;
    localparam int unsigned OUT_TDATA_W = 40;
    localparam int unsigned DIV_CNT_W = 4;

    // Function codes carried in the input tuser.
    localparam logic [1:0] FUNC_CHECK = 2'd0;
    localparam logic [1:0] FUNC_TRACK = 2'd1;
    localparam logic [1:0] FUNC_SET_MODE = 2'd2;
    localparam logic [1:0] FUNC_ACK = 2'd3;

    // Operating modes.
    localparam logic [1:0] MODE_STOP = 2'd0;
    localparam logic [1:0] MODE_RUN = 2'd1;
    localparam logic [1:0] MODE_ERROR = 2'd2;

    // Fault codes, in the order the redline tests run.
    localparam logic [3:0] FAULT_NONE = 4'd0;
    localparam logic [3:0] FAULT_IN_OVER_V = 4'd1;
    localparam logic [3:0] FAULT_IN_OVER_I = 4'd2;
    localparam logic [3:0] FAULT_OUT_UNDER_V = 4'd3;
    localparam logic [3:0] FAULT_OUT_OVER_V = 4'd4;
    localparam logic [3:0] FAULT_OUT_OVER_I = 4'd5;
    localparam logic [3:0] FAULT_INVERSION = 4'd6;
    localparam logic [3:0] FAULT_DUTY_LOW = 4'd7;
    localparam logic [3:0] FAULT_DUTY_HIGH = 4'd8;

    // Configuration register indexes.
    localparam logic [2:0] CFG_MAX_IN_V = 3'd0;
    localparam logic [2:0] CFG_MAX_IN_I = 3'd1;
    localparam logic [2:0] CFG_MIN_OUT_V = 3'd2;
    localparam logic [2:0] CFG_MAX_OUT_V = 3'd3;
    localparam logic [2:0] CFG_MAX_OUT_I = 3'd4;
    localparam logic [2:0] CFG_MIN_DUTY = 3'd5;
    localparam logic [2:0] CFG_MAX_DUTY = 3'd6;
    localparam logic [2:0] CFG_PERTURB_STEP = 3'd7;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_MAX_IN_V = 16'd17920;
    localparam logic [15:0] RST_MAX_IN_I = 16'd32768;
    localparam logic [15:0] RST_MIN_OUT_V = 16'd20480;
    localparam logic [15:0] RST_MAX_OUT_V = 16'd33280;
    localparam logic [15:0] RST_MAX_OUT_I = 16'd20480;
    localparam logic [15:0] RST_MIN_DUTY = 16'd6554;
    localparam logic [15:0] RST_MAX_DUTY = 16'd58982;
    localparam logic [11:0] RST_PERTURB_STEP = 12'd26;

    localparam logic [15:0] HALF_DUTY = 16'h8000;
    localparam logic [15:0] FULL_DUTY = 16'hFFFF;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;      // capture the input request
        logic apply;     // execute a non-tracking request (or an ignored one)
        logic mult;      // register the array power
        logic step;      // move the reference and update history
        logic div_iter;  // one quotient bit of the duty division
        logic post;      // write the result into the output register
    } ctrl_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic track;       // captured request is a tracking step in RUN
        logic div_needed;  // the duty needs the iterative divider
        logic div_last;    // the divider is on its final bit
        logic out_free;    // the output register can take a result
    } ctrl_sts_t;

endpackage

/* rtl/core/mppt_po_ctrl.sv */
// ----------------------------------------------------------------------------
// mppt_po_ctrl
// Sequencer for one request at a time: decode, power multiply, reference
// step, bit-serial duty division and result hand-off.
// ----------------------------------------------------------------------------
module mppt_po_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  mppt_po_pkg::ctrl_sts_t sts,
    output mppt_po_pkg::ctrl_cmd_t cmd
);
    import mppt_po_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_EXEC = 5'b00010,
        ST_STEP = 5'b00100,
        ST_DIV  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        s_tready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.track)
                begin
                    cmd.mult = 1'b1;
                    state_next = ST_STEP;
                end
                else
                begin
                    cmd.apply = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_STEP:
            begin
                cmd.step = 1'b1;
                state_next = sts.div_needed ? ST_DIV : ST_DONE;
            end
            ST_DIV:
            begin
                cmd.div_iter = 1'b1;
                if (sts.div_last)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.post = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/core/mppt_po_dp.sv */
// ----------------------------------------------------------------------------
// mppt_po_dp
// Datapath: configuration registers, tracker state, redline checker, power
// multiplier, restoring divider for the duty and the output register.
// ----------------------------------------------------------------------------
module mppt_po_dp
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [mppt_po_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  logic [mppt_po_pkg::DATA_W-1:0]        cfg_wdata,
    input  logic [mppt_po_pkg::IN_TDATA_W-1:0]    s_tdata,
    input  logic [1:0]                            s_tuser,
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [mppt_po_pkg::OUT_TDATA_W-1:0]   m_tdata,
    input  mppt_po_pkg::ctrl_cmd_t                cmd,
    output mppt_po_pkg::ctrl_sts_t                sts
);
    import mppt_po_pkg::*;

    // Configuration.
    logic [15:0] max_in_v_reg, max_in_i_reg, min_out_v_reg, max_out_v_reg;
    logic [15:0] max_out_i_reg, min_duty_reg, max_duty_reg;
    logic [11:0] step_reg;

    // Tracker state.
    logic [1:0]  mode_reg;
    logic        run_latch_reg;
    logic [15:0] last_v_reg;
    logic [31:0] last_p_reg;
    logic [15:0] duty_reg;
    logic [15:0] target_reg;
    logic [3:0]  fault_reg;
    logic        raised_reg;

    // Captured request.
    logic [1:0]  func_reg;
    logic [15:0] av_reg, ai_reg, bv_reg, bi_reg;
    logic        req_reg;

    // Work registers.
    logic [31:0] power_reg;
    logic [15:0] rem_reg;
    logic [15:0] quo_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;

    // Output register.
    logic        out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    // Redline tests in priority order.
    logic [3:0] crossing;
    always_comb
    begin
        if (av_reg > max_in_v_reg)
            crossing = FAULT_IN_OVER_V;
        else if (ai_reg > max_in_i_reg)
            crossing = FAULT_IN_OVER_I;
        else if (bv_reg < min_out_v_reg)
            crossing = FAULT_OUT_UNDER_V;
        else if (bv_reg > max_out_v_reg)
            crossing = FAULT_OUT_OVER_V;
        else if (bi_reg > max_out_i_reg)
            crossing = FAULT_OUT_OVER_I;
        else if (av_reg >= bv_reg)
            crossing = FAULT_INVERSION;
        else if (duty_reg < min_duty_reg)
            crossing = FAULT_DUTY_LOW;
        else if (duty_reg > max_duty_reg)
            crossing = FAULT_DUTY_HIGH;
        else
            crossing = FAULT_NONE;
    end

    // Reference step: one stride toward rising power, clamped to 16 bits.
    logic        step_up;
    logic [16:0] ref_sum;
    logic [15:0] ref_val;
    always_comb
    begin
        if (power_reg >= last_p_reg)
            step_up = av_reg > last_v_reg;
        else
            step_up = av_reg < last_v_reg;
        ref_sum = {1'b0, av_reg} + {5'd0, step_reg};
        if (step_up)
            ref_val = ref_sum[16] ? FULL_DUTY : ref_sum[15:0];
        else if (av_reg < {4'd0, step_reg})
            ref_val = '0;
        else
            ref_val = av_reg - {4'd0, step_reg};
    end

    // The quotient fits in 16 bits exactly when the reference is below the
    // battery voltage; otherwise the duty saturates.
    logic div_needed;
    assign div_needed = (bv_reg != '0) && (ref_val < bv_reg);

    // One restoring-division bit per cycle.
    logic [16:0] rem_shift;
    logic        rem_ge;
    logic [15:0] rem_new;
    logic [15:0] quo_new;
    always_comb
    begin
        rem_shift = {rem_reg, 1'b0};
        rem_ge = rem_shift >= {1'b0, bv_reg};
        rem_new = rem_ge ? 16'(rem_shift - {1'b0, bv_reg}) : rem_shift[15:0];
        quo_new = {quo_reg[14:0], rem_ge};
    end

    assign sts.track = (func_reg == FUNC_TRACK) && (mode_reg == MODE_RUN);
    assign sts.div_needed = div_needed;
    assign sts.div_last = (cnt_reg == '0);
    assign sts.out_free = !out_valid_reg || m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_in_v_reg <= RST_MAX_IN_V;
            max_in_i_reg <= RST_MAX_IN_I;
            min_out_v_reg <= RST_MIN_OUT_V;
            max_out_v_reg <= RST_MAX_OUT_V;
            max_out_i_reg <= RST_MAX_OUT_I;
            min_duty_reg <= RST_MIN_DUTY;
            max_duty_reg <= RST_MAX_DUTY;
            step_reg <= RST_PERTURB_STEP;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_MAX_IN_V:     max_in_v_reg <= cfg_wdata;
                CFG_MAX_IN_I:     max_in_i_reg <= cfg_wdata;
                CFG_MIN_OUT_V:    min_out_v_reg <= cfg_wdata;
                CFG_MAX_OUT_V:    max_out_v_reg <= cfg_wdata;
                CFG_MAX_OUT_I:    max_out_i_reg <= cfg_wdata;
                CFG_MIN_DUTY:     min_duty_reg <= cfg_wdata;
                CFG_MAX_DUTY:     max_duty_reg <= cfg_wdata;
                CFG_PERTURB_STEP: step_reg <= cfg_wdata[STEP_W-1:0];
                default:          ;
            endcase
        end
    end

    // Captured request and work registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            func_reg <= s_tuser;
            av_reg <= s_tdata[15:0];
            ai_reg <= s_tdata[31:16];
            bv_reg <= s_tdata[47:32];
            bi_reg <= s_tdata[63:48];
            req_reg <= s_tdata[64];
        end
        if (cmd.mult)
        begin
            power_reg <= av_reg * ai_reg;
        end
        if (cmd.step)
        begin
            rem_reg <= ref_val;
            cnt_reg <= DIV_CNT_W'(DATA_W - 1);
        end
        else if (cmd.div_iter)
        begin
            rem_reg <= rem_new;
            quo_reg <= quo_new;
            cnt_reg <= cnt_reg - 1'b1;
        end
        if (cmd.post)
        begin
            out_data_reg <= {raised_reg, fault_reg, target_reg, duty_reg,
                             mode_reg == MODE_RUN, mode_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= MODE_STOP;
            run_latch_reg <= 1'b0;
            last_v_reg <= '0;
            last_p_reg <= '0;
            duty_reg <= HALF_DUTY;
            target_reg <= '0;
            fault_reg <= FAULT_NONE;
            raised_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                raised_reg <= 1'b0;
            end

            if (cmd.apply)
            begin
                case (func_reg)
                    FUNC_CHECK:
                    begin
                        if (crossing != FAULT_NONE)
                        begin
                            raised_reg <= 1'b1;
                            if (fault_reg == FAULT_NONE)
                                fault_reg <= crossing;
                            mode_reg <= MODE_ERROR;
                            duty_reg <= HALF_DUTY;
                            last_v_reg <= '0;
                            last_p_reg <= '0;
                        end
                    end
                    FUNC_SET_MODE:
                    begin
                        run_latch_reg <= req_reg;
                        if ((mode_reg == MODE_STOP && req_reg) ||
                            (mode_reg == MODE_RUN && req_reg))
                        begin
                            mode_reg <= MODE_RUN;
                        end
                        else
                        begin
                            if (mode_reg == MODE_RUN)
                                mode_reg <= MODE_STOP;
                            duty_reg <= HALF_DUTY;
                            last_v_reg <= '0;
                            last_p_reg <= '0;
                        end
                    end
                    FUNC_ACK:
                    begin
                        if (mode_reg == MODE_ERROR)
                        begin
                            fault_reg <= FAULT_NONE;
                            run_latch_reg <= 1'b0;
                            mode_reg <= MODE_STOP;
                            duty_reg <= HALF_DUTY;
                            last_v_reg <= '0;
                            last_p_reg <= '0;
                        end
                    end
                    default:
                    begin
                        // Tracking step outside RUN: no effect.
                    end
                endcase
            end

            if (cmd.step)
            begin
                target_reg <= ref_val;
                last_v_reg <= av_reg;
                last_p_reg <= power_reg;
                if (!div_needed)
                    duty_reg <= FULL_DUTY;
            end

            if (cmd.div_iter && sts.div_last)
            begin
                duty_reg <= quo_new;
            end

            if (cmd.post)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

/* rtl/core/mppt_perturb_observe_with_protection_top.sv */
// ----------------------------------------------------------------------------
// mppt_perturb_observe_with_protection_top
// Perturb-and-observe maximum power point tracker with redline protection.
// ----------------------------------------------------------------------------
// Sequence: a check, set-mode or acknowledge request is applied and its result
// posted; a tracking step in RUN multiplies, steps the reference and runs the
// bit-serial duty divider before posting. A saturated duty skips the divider.
// Throughput: one request at a time; the next is accepted only after the
// result is posted, which waits until the output register is free.
// Reset (rst_n, asynchronous): STOP mode, half duty, no fault, limits at
// their defaults, output register empty.
// ----------------------------------------------------------------------------
//
// Every accepted request produces exactly one result. The controller walks
// each request through decode and, for a tracking step in RUN, a multiply of
// array voltage by array current, the reference step and, unless the duty
// saturates, a restoring division of the reference (shifted up by 16) over
// the battery voltage. The result is then placed in an output register, so
// a new request can be accepted while the previous result is still waiting
// for the downstream side. Configuration writes land directly in the datapath
// registers and are expected only while no request is in flight.
module mppt_perturb_observe_with_protection_top
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata,
    // Request stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] array_voltage, [31:16] array_current, [47:32] battery_voltage,
    // [63:48] battery_current, [64] run_request, [71:65] zero
    input  logic [71:0] s_tdata,
    // [1:0] func
    input  logic [1:0]  s_tuser,
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] op_mode, [2] pwm_on, [18:3] duty_cycle, [34:19] reference_voltage,
    // [38:35] fault_code, [39] fault_raised
    output logic [39:0] m_tdata
);
    import mppt_po_pkg::*;

    ctrl_cmd_t cmd;
    ctrl_sts_t sts;

    // The controller owns the request handshake; the datapath owns the result.
    mppt_po_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    mppt_po_dp u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule
